// ===== src/tdas_pkg.sv =====
// ----------------------------------------------------------------------------
// tdas_pkg
// Shared constants, register indexes and item layouts for the touch
// debounce and scaling block.
// ----------------------------------------------------------------------------
package tdas_pkg;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;

   localparam int RAW_W    = 12;
   localparam int SIZE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   // quotient bits: the scaled coordinate never exceeds the screen size
   localparam int SIZE_W   = $clog2(SIZE_MAX + 1);
   localparam int CNT_W    = $clog2(SIZE_W + 1);

   localparam int SX_W     = 9;
   localparam int SY_W     = 8;
   localparam int CNT8_W   = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_X_CAL_MIN       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_X_CAL_MAX       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_Y_CAL_MIN       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_Y_CAL_MAX       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBUG_MODE      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_LIMIT  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_COOLDOWN_RELOAD = 3'd6;

   localparam logic [CNT8_W-1:0] LIMIT_MAX = 8'd254;
   localparam logic [CNT8_W-1:0] COUNT_MAX = 8'd255;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic {
      AXIS_X = 1'b0,
      AXIS_Y = 1'b1
   } axis_type;

   typedef struct packed {
      logic     start;
      axis_type axis;
   } scale_ctl_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_y;
      logic [RAW_W-1:0] raw_x;
      logic             pressed;
   } req_item_type;

   typedef struct packed {
      logic [SY_W-1:0] screen_y;
      logic [SX_W-1:0] screen_x;
      logic            is_down;
      logic            debug_plot;
      logic            press_event;
   } rsp_item_type;

endpackage

// ===== src/tdas_scale.sv =====
// ----------------------------------------------------------------------------
// tdas_scale
// Linear calibration of one axis: normalizes the span sign, multiplies by
// the screen size and runs a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdas_scale
   import tdas_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  scale_ctl_type      ctl,
   input  logic [RAW_W-1:0]   raw,
   input  logic [RAW_W-1:0]   cal_lo,
   input  logic [RAW_W-1:0]   cal_hi,
   output logic               done,
   output logic [SIZE_W-1:0]  coord
);

   localparam int PROD_W = RAW_W + SIZE_W;

   typedef enum logic [2:0] {
      SC_IDLE = 3'b001,
      SC_DIV  = 3'b010,
      SC_DONE = 3'b100
   } sc_state_type;

   sc_state_type        state_ff, state_in;
   logic [RAW_W-1:0]    rem_ff, rem_in;
   logic [SIZE_W-1:0]   quo_ff, quo_in;
   logic [RAW_W-1:0]    span_ff, span_in;
   logic                bad_ff, bad_in;
   axis_type            axis_ff, axis_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic [RAW_W:0]      d_ext, s_ext, d_abs, s_abs;
   logic                bad_now;
   logic [SIZE_W-1:0]   size;
   logic [PROD_W-1:0]   prod;
   logic [RAW_W:0]      trial, diff;
   logic                fits;

   // flip both operands when the calibration is reversed
   assign d_ext   = {1'b0, raw} - {1'b0, cal_lo};
   assign s_ext   = {1'b0, cal_hi} - {1'b0, cal_lo};
   assign d_abs   = s_ext[RAW_W] ? -d_ext : d_ext;
   assign s_abs   = s_ext[RAW_W] ? -s_ext : s_ext;
   // out of range or zero span gives 0
   assign bad_now = (s_abs == '0) || d_abs[RAW_W] || (d_abs > s_abs);
   assign size    = (ctl.axis == AXIS_X) ? SIZE_W'(SCREEN_WIDTH) : SIZE_W'(SCREEN_HEIGHT);
   assign prod    = PROD_W'(d_abs[RAW_W-1:0]) * PROD_W'(size);

   assign trial = {rem_ff, quo_ff[SIZE_W-1]};
   assign diff  = trial - {1'b0, span_ff};
   assign fits  = (trial >= {1'b0, span_ff});

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      span_in  = span_ff;
      bad_in   = bad_ff;
      axis_in  = axis_ff;
      cnt_in   = cnt_ff;
      if (ctl.start) begin
         // in range the upper product bits are already below the span
         rem_in   = prod[PROD_W-1:SIZE_W];
         quo_in   = prod[SIZE_W-1:0];
         span_in  = s_abs[RAW_W-1:0];
         bad_in   = bad_now;
         axis_in  = ctl.axis;
         cnt_in   = '0;
         state_in = SC_DIV;
      end else begin
         unique case (state_ff)
            SC_IDLE: begin
               state_in = SC_IDLE;
            end
            SC_DIV: begin
               rem_in = fits ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
               quo_in = {quo_ff[SIZE_W-2:0], fits};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(SIZE_W - 1)) begin
                  state_in = SC_DONE;
               end
            end
            SC_DONE: begin
               state_in = SC_IDLE;
            end
            default: begin
               state_in = SC_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      span_ff <= span_in;
      bad_ff  <= bad_in;
      axis_ff <= axis_in;
      cnt_ff  <= cnt_in;
   end

   assign done = (state_ff == SC_DONE);

   // X is flipped and rounded up, Y is rounded down
   always_comb begin
      if (bad_ff) begin
         coord = '0;
      end else if (axis_ff == AXIS_X) begin
         coord = SIZE_W'(SCREEN_WIDTH) - quo_ff - SIZE_W'(rem_ff != '0);
      end else begin
         coord = quo_ff;
      end
   end

endmodule

// ===== src/touch_debounce_and_scale.sv =====
// ----------------------------------------------------------------------------
// touch_debounce_and_scale
// Touch press debouncing, debug plot cooldown and linear calibration of the
// raw touch samples to screen pixels.
// ----------------------------------------------------------------------------
// An item that captures a coordinate waits on the shared serial divider, which
// makes one quotient bit per cycle for X and then Y; any other item goes
// straight to the output stage.
// Flow: one item in work at a time; the next is accepted the cycle after the
// result enters the output register, which waits while that register is full.
// Reset: synchronous, active high, restores configuration and touch state.
module touch_debounce_and_scale
   import tdas_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [0] pressed, [12:1] raw_x, [24:13] raw_y, [31:25] zero
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // response stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [0] press_event, [1] debug_plot, [2] is_down, [11:3] screen_x,
   // [19:12] screen_y, [23:20] zero
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   // register write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SCALE_X = 4'b0010,
      ST_SCALE_Y = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   state_type          state_ff, state_in;

   logic [RAW_W-1:0]   x_min_ff, x_min_in, x_max_ff, x_max_in;
   logic [RAW_W-1:0]   y_min_ff, y_min_in, y_max_ff, y_max_in;
   logic               debug_ff, debug_in;
   logic [CNT8_W-1:0]  limit_ff, limit_in, reload_ff, reload_in;

   logic               down_ff, down_in;
   logic [CNT8_W-1:0]  release_ff, release_in, cool_ff, cool_in;
   logic [SX_W-1:0]    last_x_ff, last_x_in;
   logic [SY_W-1:0]    last_y_ff, last_y_in;

   logic [RAW_W-1:0]   raw_y_ff, raw_y_in;
   logic               event_ff, event_in, plot_ff, plot_in, is_down_ff, is_down_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   req_item_type       req_item;
   logic               accept, capture;
   logic [CNT8_W-1:0]  limit_eff;

   scale_ctl_type      scl_ctl;
   logic [RAW_W-1:0]   scl_raw, scl_lo, scl_hi;
   logic               scl_done;
   logic [SIZE_W-1:0]  scl_coord;

   assign req_item   = req_tdata[$bits(req_item_type)-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign limit_eff  = (limit_ff > LIMIT_MAX) ? LIMIT_MAX : limit_ff;

   assign capture = debug_ff ? (req_item.pressed && (cool_ff == '0))
                             : (req_item.pressed && !down_ff);

   // X is started at accept, Y as soon as X finishes
   always_comb begin
      scl_ctl.start = (state_ff == ST_IDLE && accept && capture) ||
                      (state_ff == ST_SCALE_X && scl_done);
      if (state_ff == ST_IDLE) begin
         scl_ctl.axis = AXIS_X;
         scl_raw      = req_item.raw_x;
         scl_lo       = x_min_ff;
         scl_hi       = x_max_ff;
      end else begin
         scl_ctl.axis = AXIS_Y;
         scl_raw      = raw_y_ff;
         scl_lo       = y_min_ff;
         scl_hi       = y_max_ff;
      end
   end

   tdas_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .ctl    (scl_ctl),
      .raw    (scl_raw),
      .cal_lo (scl_lo),
      .cal_hi (scl_hi),
      .done   (scl_done),
      .coord  (scl_coord)
   );

   always_comb begin
      state_in     = state_ff;
      x_min_in     = x_min_ff;
      x_max_in     = x_max_ff;
      y_min_in     = y_min_ff;
      y_max_in     = y_max_ff;
      debug_in     = debug_ff;
      limit_in     = limit_ff;
      reload_in    = reload_ff;
      down_in      = down_ff;
      release_in   = release_ff;
      cool_in      = cool_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      raw_y_in     = raw_y_ff;
      event_in     = event_ff;
      plot_in      = plot_ff;
      is_down_in   = is_down_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_item_in  = rsp_item_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_addr)
            CSR_X_CAL_MIN:       x_min_in  = csr_wdata[RAW_W-1:0];
            CSR_X_CAL_MAX:       x_max_in  = csr_wdata[RAW_W-1:0];
            CSR_Y_CAL_MIN:       y_min_in  = csr_wdata[RAW_W-1:0];
            CSR_Y_CAL_MAX:       y_max_in  = csr_wdata[RAW_W-1:0];
            CSR_DEBUG_MODE: begin
               // mode change drops any touch in progress
               debug_in   = csr_wdata[0];
               down_in    = 1'b0;
               release_in = '0;
            end
            CSR_DEBOUNCE_LIMIT:  limit_in  = csr_wdata[CNT8_W-1:0];
            CSR_COOLDOWN_RELOAD: reload_in = csr_wdata[CNT8_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               event_in = 1'b0;
               plot_in  = 1'b0;
               raw_y_in = req_item.raw_y;
               if (debug_ff) begin
                  if (req_item.pressed) begin
                     if (cool_ff != '0) begin
                        cool_in = cool_ff - 1'b1;
                     end else begin
                        cool_in = reload_ff;
                        plot_in = 1'b1;
                     end
                  end
               end else if (!down_ff) begin
                  if (req_item.pressed) begin
                     down_in    = 1'b1;
                     release_in = '0;
                     event_in   = 1'b1;
                  end
               end else if (req_item.pressed) begin
                  release_in = '0;
               end else begin
                  if (release_ff != COUNT_MAX) begin
                     release_in = release_ff + 1'b1;
                  end
                  // end the touch once the release outlasts the limit
                  if (release_ff > limit_eff) begin
                     down_in    = 1'b0;
                     release_in = '0;
                  end
               end
               is_down_in = !debug_ff && down_in;
               state_in   = capture ? ST_SCALE_X : ST_EMIT;
            end
         end
         ST_SCALE_X: begin
            if (scl_done) begin
               last_x_in = scl_coord[SX_W-1:0];
               state_in  = ST_SCALE_Y;
            end
         end
         ST_SCALE_Y: begin
            if (scl_done) begin
               last_y_in = scl_coord[SY_W-1:0];
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.press_event  = event_ff;
               rsp_item_in.debug_plot   = plot_ff;
               rsp_item_in.is_down      = is_down_ff;
               rsp_item_in.screen_x     = last_x_ff;
               rsp_item_in.screen_y     = last_y_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_min_ff     <= RAW_W'(275);
         x_max_ff     <= RAW_W'(3800);
         y_min_ff     <= RAW_W'(275);
         y_max_ff     <= RAW_W'(3800);
         debug_ff     <= 1'b0;
         limit_ff     <= CNT8_W'(50);
         reload_ff    <= CNT8_W'(50);
         down_ff      <= 1'b0;
         release_ff   <= '0;
         cool_ff      <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_min_ff     <= x_min_in;
         x_max_ff     <= x_max_in;
         y_min_ff     <= y_min_in;
         y_max_ff     <= y_max_in;
         debug_ff     <= debug_in;
         limit_ff     <= limit_in;
         reload_ff    <= reload_in;
         down_ff      <= down_in;
         release_ff   <= release_in;
         cool_ff      <= cool_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      raw_y_ff    <= raw_y_in;
      event_ff    <= event_in;
      plot_ff     <= plot_in;
      is_down_ff  <= is_down_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - $bits(rsp_item_type))'(0), rsp_item_ff};

endmodule
